@@ hdl/dqsc_pkg.sv @@
// Shared types and constants for the DQS delay tap calibration core.
// No dependencies.
`default_nettype none

package dqsc_pkg;

    localparam int TAP_W  = 6;
    localparam int WORD_W = 16;
    localparam int FAIL_W = 8;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    localparam logic [TAP_W-1:0] RST_MAX_TAP     = 6'd63;
    localparam logic [TAP_W-1:0] RST_DEFAULT_TAP = 6'd8;

    typedef enum logic [1:0] {
        REG_MAX_TAP     = 2'd0,
        REG_DEFAULT_TAP = 2'd1,
        REG_WIDE_BUS    = 2'd2,
        REG_SPLIT_CHAIN = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [TAP_W-1:0] tap;
        logic             finished;
        logic             found;
        logic [TAP_W-1:0] low;
        logic [TAP_W-1:0] high;
    } sweep_res_t;

endpackage

`default_nettype wire

@@ hdl/dqsc_sweep.sv @@
// Sweep state and per-beat window update.
// Depends on dqsc_pkg.
`default_nettype none

module dqsc_sweep
    import dqsc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              opcode,
    input  wire logic [FAIL_W-1:0] fail_count,
    input  wire logic [TAP_W-1:0]  max_tap,
    input  wire logic [TAP_W-1:0]  default_tap,
    output sweep_res_t             res
);

    logic             sweeping_reg, sweeping_next;
    logic [TAP_W-1:0] cur_reg, cur_next;
    logic             found_reg, found_next;
    logic [TAP_W-1:0] low_reg, low_next;
    logic [TAP_W-1:0] high_reg, high_next;
    logic [TAP_W-1:0] applied_reg, applied_next;

    always_comb
    begin
        logic           done;
        logic [TAP_W:0] sum;
        sweeping_next = sweeping_reg;
        cur_next      = cur_reg;
        found_next    = found_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        applied_next  = applied_reg;
        done          = 1'b0;
        sum           = '0;
        if (opcode == OP_START)
        begin
            sweeping_next = 1'b1;
            cur_next      = '0;
            found_next    = 1'b0;
            low_next      = '0;
            high_next     = '0;
            applied_next  = '0;
        end
        else if (sweeping_reg)
        begin
            if (fail_count == '0)
            begin
                if (!found_reg)
                begin
                    low_next = cur_reg;
                end
                high_next  = cur_reg;
                found_next = 1'b1;
            end
            else if (found_reg)
            begin
                if (cur_reg != '0)
                begin
                    high_next = cur_reg - 1'b1;
                end
                done = 1'b1;
            end
            if (cur_reg >= max_tap)
            begin
                done = 1'b1;
            end
            if (done)
            begin
                sum = {1'b0, high_next} + {1'b0, low_next} + 1'b1;
                applied_next  = found_next ? sum[TAP_W:1] : default_tap;
                sweeping_next = 1'b0;
            end
            else
            begin
                cur_next     = cur_reg + 1'b1;
                applied_next = cur_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweeping_reg <= 1'b0;
            cur_reg      <= '0;
            found_reg    <= 1'b0;
            low_reg      <= '0;
            high_reg     <= '0;
            applied_reg  <= RST_DEFAULT_TAP;
        end
        else if (adv)
        begin
            sweeping_reg <= sweeping_next;
            cur_reg      <= cur_next;
            found_reg    <= found_next;
            low_reg      <= low_next;
            high_reg     <= high_next;
            applied_reg  <= applied_next;
        end
    end

    assign res.tap      = applied_next;
    assign res.finished = !sweeping_next;
    assign res.found    = found_next;
    assign res.low      = low_next;
    assign res.high     = high_next;

endmodule

`default_nettype wire

@@ hdl/dqsc_tap_enc.sv @@
// Two-chain tap register word encoder.
// Depends on dqsc_pkg.
`default_nettype none

module dqsc_tap_enc
    import dqsc_pkg::*;
#(
    parameter int LOW_CHAIN_BITS   = 5,
    parameter int HIGH_CHAIN_SHIFT = 8
)
(
    input  wire logic [TAP_W-1:0]  tap,
    input  wire logic [TAP_W-1:0]  max_tap,
    input  wire logic              split_chain,
    output      logic [WORD_W-1:0] word
);

    localparam logic [TAP_W-1:0] LowMask = TAP_W'((1 << LOW_CHAIN_BITS) - 1);

    logic [TAP_W-1:0] half;
    logic [TAP_W-1:0] upper;

    assign half  = max_tap >> 1;
    assign upper = tap - half;

    always_comb
    begin
        if (split_chain && (tap > half))
        begin
            word = WORD_W'(tap & LowMask)
                 | (WORD_W'(upper) << HIGH_CHAIN_SHIFT);
        end
        else
        begin
            word = WORD_W'(tap);
        end
    end

endmodule

`default_nettype wire

@@ hdl/dqs_delay_tap_calibration_core.sv @@
// Top level: APB registers, input stage, result register.
// Depends on dqsc_pkg, dqsc_sweep, dqsc_tap_enc.
//
//  channel | direction | handshake           | beat
//  in      | sink      | in_valid / in_stall   | opcode, fail_count
//  out     | source    | out_valid / out_stall | tap_value .. window_high
//  apb     | slave     | psel/penable/pready   | paddr, pwdata, prdata
//
// Input stage, then result register; one beat per cycle while out_stall is low;
// the sweep state update sits between the input stage and the result register.
// Reset clears the sweep state (applied tap 8) and the registers to defaults.
// out_stall backs up through the result register into in_stall in the same cycle.
`default_nettype none

module dqs_delay_tap_calibration_core
    import dqsc_pkg::*;
#(
    parameter int LOW_CHAIN_BITS   = 5,
    parameter int HIGH_CHAIN_SHIFT = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output      logic [31:0]       prdata,
    output      logic              pready,
    input  wire logic              in_valid,
    output      logic              in_stall,
    input  wire logic              opcode,
    input  wire logic [FAIL_W-1:0] fail_count,
    output      logic              out_valid,
    input  wire logic              out_stall,
    output      logic [TAP_W-1:0]  tap_value,
    output      logic [WORD_W-1:0] tap_word,
    output      logic              upper_lanes,
    output      logic              finished,
    output      logic              window_found,
    output      logic [TAP_W-1:0]  window_low,
    output      logic [TAP_W-1:0]  window_high
);

    logic [TAP_W-1:0] max_tap_reg;
    logic [TAP_W-1:0] default_tap_reg;
    logic             wide_bus_reg;
    logic             split_chain_reg;
    reg_idx_t         idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tap_reg     <= RST_MAX_TAP;
            default_tap_reg <= RST_DEFAULT_TAP;
            wide_bus_reg    <= 1'b1;
            split_chain_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MAX_TAP:     max_tap_reg     <= pwdata[TAP_W-1:0];
                REG_DEFAULT_TAP: default_tap_reg <= pwdata[TAP_W-1:0];
                REG_WIDE_BUS:    wide_bus_reg    <= pwdata[0];
                REG_SPLIT_CHAIN: split_chain_reg <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MAX_TAP:     prdata = 32'(max_tap_reg);
            REG_DEFAULT_TAP: prdata = 32'(default_tap_reg);
            REG_WIDE_BUS:    prdata = 32'(wide_bus_reg);
            REG_SPLIT_CHAIN: prdata = 32'(split_chain_reg);
        endcase
    end

    // input stage
    logic              s1_valid_reg;
    logic              s1_op_reg;
    logic [FAIL_W-1:0] s1_fail_reg;
    logic              out_free;
    logic              s1_adv;
    logic              in_acc;

    assign out_free = !out_valid || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_acc   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_op_reg   <= opcode;
            s1_fail_reg <= fail_count;
        end
    end

    sweep_res_t        res;
    logic [WORD_W-1:0] word;

    dqsc_sweep u_sweep (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (s1_adv),
        .opcode      (s1_op_reg),
        .fail_count  (s1_fail_reg),
        .max_tap     (max_tap_reg),
        .default_tap (default_tap_reg),
        .res         (res)
    );

    dqsc_tap_enc #(
        .LOW_CHAIN_BITS   (LOW_CHAIN_BITS),
        .HIGH_CHAIN_SHIFT (HIGH_CHAIN_SHIFT)
    ) u_enc (
        .tap         (res.tap),
        .max_tap     (max_tap_reg),
        .split_chain (split_chain_reg),
        .word        (word)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            tap_value    <= res.tap;
            tap_word     <= word;
            upper_lanes  <= wide_bus_reg;
            finished     <= res.finished;
            window_found <= res.found;
            window_low   <= res.low;
            window_high  <= res.high;
        end
    end

`ifndef SYNTH
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid && out_stall) |-> in_stall)
        else $error("input taken while pipeline blocked");

    a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_valid_reg))
        else $error("result without input stage beat");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> s1_valid_reg)
        else $error("input stage beat dropped");

    a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && window_found) |-> (window_low <= window_high))
        else $error("window ends out of order");

    a_window_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !window_found) |-> (window_low == '0 && window_high == '0))
        else $error("window ends set without pass");
`endif

endmodule

`default_nettype wire

@@ verif/tb_dqs_delay_tap_calibration_core.sv @@
// Testbench for dqs_delay_tap_calibration_core: directed and random tap sweeps
// with random idle and stall, checked against an in-bench tap sweep tracker.
// Depends on dqsc_pkg and the core RTL.
`default_nettype none

module tb_dqs_delay_tap_calibration_core import dqsc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LOW_BITS    = 5;
    localparam int HIGH_SHIFT  = 8;
    localparam int LIVE_TARGET = 1900;

    typedef struct packed {
        logic [TAP_W-1:0]  tap;
        logic [WORD_W-1:0] word;
        logic              upper;
        logic              finished;
        logic              found;
        logic [TAP_W-1:0]  low;
        logic [TAP_W-1:0]  high;
    } tap_result_t;

    class tap_sweep_tracker;
        int               low_bits;
        int               high_shift;
        logic [TAP_W-1:0] max_tap;
        logic [TAP_W-1:0] default_tap;
        logic             wide_bus;
        logic             split_chain;
        logic             sweeping;
        logic             found;
        logic [TAP_W-1:0] cur_tap;
        logic [TAP_W-1:0] low_end;
        logic [TAP_W-1:0] high_end;
        logic [TAP_W-1:0] applied;
        tap_result_t      taps_due[$];
        int               errors;
        int               checked;
        int               live_beats;

        function new(int lb, int hs);
            low_bits    = lb;
            high_shift  = hs;
            max_tap     = RST_MAX_TAP;
            default_tap = RST_DEFAULT_TAP;
            wide_bus    = 1'b1;
            split_chain = 1'b0;
            sweeping    = 1'b0;
            found       = 1'b0;
            cur_tap     = '0;
            low_end     = '0;
            high_end    = '0;
            applied     = RST_DEFAULT_TAP;
            errors      = 0;
            checked     = 0;
            live_beats  = 0;
        endfunction

        function int pending();
            return taps_due.size();
        endfunction

        function void set_reg(reg_idx_t idx, logic [31:0] v);
            case (idx)
                REG_MAX_TAP:     max_tap     = v[TAP_W-1:0];
                REG_DEFAULT_TAP: default_tap = v[TAP_W-1:0];
                REG_WIDE_BUS:    wide_bus    = v[0];
                REG_SPLIT_CHAIN: split_chain = v[0];
                default:         ;
            endcase
        endfunction

        // One input beat in, one expected result out.
        function void predict_tap(logic op, logic [FAIL_W-1:0] fails);
            bit               done;
            int               avg;
            int               w;
            logic [TAP_W-1:0] half;
            tap_result_t      r;
            done = 1'b0;
            if (op == OP_START)
            begin
                live_beats++;
                sweeping = 1'b1;
                cur_tap  = '0;
                found    = 1'b0;
                low_end  = '0;
                high_end = '0;
                applied  = '0;
            end
            else if (sweeping)
            begin
                live_beats++;
                if (fails == '0)
                begin
                    if (!found)
                    begin
                        low_end = cur_tap;
                        found   = 1'b1;
                    end
                    high_end = cur_tap;
                end
                else if (found)
                begin
                    if (cur_tap != '0)
                        high_end = cur_tap - 1'b1;
                    done = 1'b1;
                end
                if (!done && cur_tap >= max_tap)
                    done = 1'b1;
                if (done)
                begin
                    avg      = (int'(high_end) + int'(low_end) + 1) / 2;
                    applied  = found ? avg[TAP_W-1:0] : default_tap;
                    sweeping = 1'b0;
                end
                else
                begin
                    cur_tap = cur_tap + 1'b1;
                    applied = cur_tap;
                end
            end
            half = max_tap >> 1;
            w    = int'(applied);
            if (split_chain && applied > half)
                w = (w & ((1 << low_bits) - 1)) | ((w - int'(half)) << high_shift);
            r.tap      = applied;
            r.word     = w[WORD_W-1:0];
            r.upper    = wide_bus;
            r.finished = !sweeping;
            r.found    = found;
            r.low      = low_end;
            r.high     = high_end;
            taps_due.push_back(r);
        endfunction

        function void compare(string name, logic [15:0] want_v, logic [15:0] got_v);
            if (want_v !== got_v)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: %s expected %0d, actual %0d", $time, name, want_v, got_v);
            end
        endfunction

        function void check_tap(tap_result_t got);
            tap_result_t want;
            if (taps_due.size() == 0)
            begin
                errors++;
                if (errors <= 40)
                    $display("%0t: result beat with nothing outstanding, expected none, actual tap %0d",
                             $time, got.tap);
                return;
            end
            want = taps_due.pop_front();
            checked++;
            compare("tap_value", 16'(want.tap), 16'(got.tap));
            compare("tap_word", want.word, got.word);
            compare("upper_lanes", 16'(want.upper), 16'(got.upper));
            compare("finished", 16'(want.finished), 16'(got.finished));
            compare("window_found", 16'(want.found), 16'(got.found));
            compare("window_low", 16'(want.low), 16'(got.low));
            compare("window_high", 16'(want.high), 16'(got.high));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [3:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic              opcode;
    logic [FAIL_W-1:0] fail_count;
    logic              out_valid;
    logic              out_stall;
    logic [TAP_W-1:0]  tap_value;
    logic [WORD_W-1:0] tap_word;
    logic              upper_lanes;
    logic              finished;
    logic              window_found;
    logic [TAP_W-1:0]  window_low;
    logic [TAP_W-1:0]  window_high;

    tap_sweep_tracker tap_tracker;
    tap_result_t      seen_res;
    bit               no_idle = 1'b0;
    int               sweeps_run = 0;
    int               settings_used = 0;

    dqs_delay_tap_calibration_core #(
        .LOW_CHAIN_BITS   (LOW_BITS),
        .HIGH_CHAIN_SHIFT (HIGH_SHIFT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .fail_count   (fail_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .tap_value    (tap_value),
        .tap_word     (tap_word),
        .upper_lanes  (upper_lanes),
        .finished     (finished),
        .window_found (window_found),
        .window_low   (window_low),
        .window_high  (window_high)
    );

    always #5 clk = ~clk;

    // mostly short gaps, now and then a long one
    function int idle_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_beat(logic op, logic [FAIL_W-1:0] fails);
        int gap;
        gap = idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        fail_count <= fails;
        do
            @(posedge clk);
        while (in_stall);
        tap_tracker.predict_tap(op, fails);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tap_tracker.set_reg(idx, v);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tap_tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(logic [TAP_W-1:0] mx, logic [TAP_W-1:0] df, logic wb, logic sc);
        drain();
        write_reg(REG_MAX_TAP, 32'(mx));
        write_reg(REG_DEFAULT_TAP, 32'(df));
        write_reg(REG_WIDE_BUS, 32'(wb));
        write_reg(REG_SPLIT_CHAIN, 32'(sc));
        settings_used++;
    endtask

    // Well-formed sweep: fails below the window, passes inside it, one fail past it.
    // Some sweeps are cut short and restarted, some get a stray report after the end.
    task automatic run_sweep(int mx);
        bit has_win;
        bit pass;
        int lo;
        int hi;
        int stop_at;
        int t;
        if ($urandom_range(0, 19) == 0)
            send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        send_beat(OP_START, 8'($urandom_range(0, 255)));
        sweeps_run++;
        has_win = ($urandom_range(0, 4) != 0);
        lo      = $urandom_range(0, mx);
        hi      = $urandom_range(lo, mx);
        stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, mx) : mx + 1;
        for (t = 0; t <= mx && t < stop_at; t++)
        begin
            pass = has_win && t >= lo && t <= hi;
            send_beat(OP_REPORT, pass ? 8'd0 : 8'($urandom_range(1, 255)));
            if (has_win && t > hi)
                break;
        end
        if (stop_at > mx && $urandom_range(0, 3) == 0)
            send_beat(OP_REPORT, 8'($urandom_range(0, 255)));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_res.tap      = tap_value;
            seen_res.word     = tap_word;
            seen_res.upper    = upper_lanes;
            seen_res.finished = finished;
            seen_res.found    = window_found;
            seen_res.low      = window_low;
            seen_res.high     = window_high;
            tap_tracker.check_tap(seen_res);
        end
    end

    initial
    begin
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            n = idle_len();
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            repeat ($urandom_range(0, 6)) @(posedge clk);
        end
    end

    initial
    begin
        logic [TAP_W-1:0] mx;
        logic [TAP_W-1:0] df;
        int               k;
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        in_valid   <= 1'b0;
        opcode     <= OP_START;
        fail_count <= '0;
        tap_tracker = new(LOW_BITS, HIGH_SHIFT);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reports before any sweep are ignored
        send_beat(OP_REPORT, 8'd0);
        send_beat(OP_REPORT, 8'd255);
        // fail, fail, pass, pass, fail: window 2..3
        send_beat(OP_START, 8'd255);
        send_beat(OP_REPORT, 8'd255);
        send_beat(OP_REPORT, 8'd1);
        send_beat(OP_REPORT, 8'd0);
        send_beat(OP_REPORT, 8'd0);
        send_beat(OP_REPORT, 8'd128);
        send_beat(OP_REPORT, 8'd0);
        // restart mid-sweep, then fail right after the first pass
        send_beat(OP_START, 8'd0);
        send_beat(OP_REPORT, 8'd0);
        send_beat(OP_START, 8'd7);
        send_beat(OP_REPORT, 8'd0);
        send_beat(OP_REPORT, 8'd64);
        // max tap zero: the first report ends the sweep
        configure(6'd0, 6'd63, 1'b0, 1'b1);
        send_beat(OP_START, 8'd0);
        send_beat(OP_REPORT, 8'd0);
        send_beat(OP_START, 8'd0);
        send_beat(OP_REPORT, 8'd2);
        configure(6'd1, 6'd0, 1'b1, 1'b1);
        send_beat(OP_START, 8'd0);
        send_beat(OP_REPORT, 8'd4);
        send_beat(OP_REPORT, 8'd0);
        send_beat(OP_START, 8'd0);
        send_beat(OP_REPORT, 8'd32);
        send_beat(OP_REPORT, 8'd16);

        while (tap_tracker.live_beats < LIVE_TARGET)
        begin
            case ($urandom_range(0, 5))
                0:       mx = 6'd1;
                1:       mx = 6'd63;
                2, 3:    mx = 6'($urandom_range(1, 12));
                default: mx = 6'($urandom_range(1, 63));
            endcase
            case ($urandom_range(0, 3))
                0:       df = 6'd0;
                1:       df = 6'd63;
                default: df = 6'($urandom_range(0, 63));
            endcase
            configure(mx, df, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            no_idle = ($urandom_range(0, 3) == 0);
            k = $urandom_range(3, 10);
            repeat (k)
            begin
                if (tap_tracker.live_beats < LIVE_TARGET)
                    run_sweep(int'(mx));
            end
        end

        in_valid <= 1'b0;
        while (tap_tracker.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Ran %0d sweeps over %0d register settings, %0d results checked, %0d errors.",
                 sweeps_run, settings_used, tap_tracker.checked, tap_tracker.errors);
        if (tap_tracker.errors == 0 && tap_tracker.pending() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        #10ms;
        $display("Timeout with %0d results outstanding.", tap_tracker.pending());
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/dqsc_pkg.sv
hdl/dqsc_sweep.sv
hdl/dqsc_tap_enc.sv
hdl/dqs_delay_tap_calibration_core.sv
verif/tb_dqs_delay_tap_calibration_core.sv
